[rtl/itat_pkg.sv]
// Package for the IP traffic accounting table: sizes, table entry layout
// and the operation, key mode and status codes. No dependencies.
package itat_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned FillW = $clog2(TableEntries + 1);

  localparam int unsigned AddrW   = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned PktW    = 32;
  localparam int unsigned ByteW   = 48;
  localparam int unsigned NumW    = 6;
  localparam int unsigned UsedW   = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ModeW   = 2;

  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [FillW-1:0]   fill_t;
  typedef logic [NumW-1:0]    num_t;
  typedef logic [UsedW-1:0]   used_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [ByteW-1:0]   bytes_t;

  typedef struct packed {
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
    logic [PktW-1:0]  pkts;
    bytes_t           bytes;
  } entry_t;

  localparam logic OpAccount = 1'b0;
  localparam logic OpRead    = 1'b1;

  localparam logic [ModeW-1:0] KeyOff  = 2'd0;
  localparam logic [ModeW-1:0] KeySrc  = 2'd1;
  localparam logic [ModeW-1:0] KeyDst  = 2'd2;
  localparam logic [ModeW-1:0] KeyBoth = 2'd3;

  localparam status_t StUpdated   = 3'd0;
  localparam status_t StInserted  = 3'd1;
  localparam status_t StFull      = 3'd2;
  localparam status_t StReadOk    = 3'd3;
  localparam status_t StReadEmpty = 3'd4;
  localparam status_t StIgnored   = 3'd5;

endpackage

[rtl/ip_traffic_accounting_table.sv]
// Per-IP traffic accounting table: entry memory, scan sequencer, counter
// update and result register. Depends on itat_pkg.
//
//   word     direction  handshake              payload
//   input    in         in_valid_i/in_ready_o   operation .. read_index
//   result   out        out_valid_o/out_ready_i status .. entries_used
//   key_mode cfg        cfg_we_i (no wait)      cfg_wdata_i
//
// One word at a time; in_ready_o is high only while no word is in work or waiting.
// Read: after accept, S_READ (memory read) and S_RDATA (registered data), then result valid.
// Account: one stored entry compared per cycle through the single memory read
// port, then a read-modify-write in S_UPD on a hit.
// Key mode off or a read beyond the fill level: result valid the cycle after accept.
// Reset clears fill level and scan state and sets key mode to KeySrc; entries at or
// above the fill level are never read. A stalled result holds until out_ready_i.
module ip_traffic_accounting_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [itat_pkg::ModeW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [itat_pkg::AddrW-1:0]          source_address_i,
  input  logic [itat_pkg::AddrW-1:0]          destination_address_i,
  input  logic [itat_pkg::LenW-1:0]           ip_total_length_i,
  input  logic [itat_pkg::NumW-1:0]           read_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [itat_pkg::StatusW-1:0]        status_o,
  output logic [itat_pkg::NumW-1:0]           entry_number_o,
  output logic [itat_pkg::AddrW-1:0]          entry_source_o,
  output logic [itat_pkg::AddrW-1:0]          entry_destination_o,
  output logic [itat_pkg::PktW-1:0]           packet_total_o,
  output logic [itat_pkg::ByteW-1:0]          byte_total_o,
  output logic [itat_pkg::UsedW-1:0]          entries_used_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [itat_pkg::ModeW-1:0] mode_q;
  itat_pkg::fill_t            fill_q, fill_d;
  itat_pkg::fill_t            scan_q, scan_d;
  logic                       pend_q, pend_d;
  itat_pkg::idx_t             pidx_q, pidx_d;

  logic [itat_pkg::AddrW-1:0] src_q, dst_q;
  logic [itat_pkg::LenW-1:0]  len_q;
  itat_pkg::num_t             ridx_q;

  itat_pkg::entry_t           mem_q [itat_pkg::TableEntries];
  itat_pkg::entry_t           rdata_q;
  logic                       rd_en;
  itat_pkg::idx_t             raddr;
  logic                       wr_en;
  itat_pkg::idx_t             waddr;
  itat_pkg::entry_t           wdata;

  itat_pkg::status_t          status_q, status_d;
  itat_pkg::num_t             num_q, num_d;
  itat_pkg::entry_t           res_q, res_d;

  logic                       accept;
  logic                       hit_s, hit_d, hit, more, full;
  logic [itat_pkg::ByteW:0]   byte_sum;
  itat_pkg::entry_t           upd;
  itat_pkg::entry_t           ins;
  itat_pkg::fill_t            ridx_ext;

  assign accept = in_valid_i && in_ready_o;

  assign hit_s = (rdata_q.src == src_q);
  assign hit_d = (rdata_q.dst == dst_q);
  always_comb begin
    case (mode_q)
      itat_pkg::KeySrc:  hit = pend_q && hit_s;
      itat_pkg::KeyDst:  hit = pend_q && hit_d;
      itat_pkg::KeyBoth: hit = pend_q && hit_s && hit_d;
      default:           hit = 1'b0;
    endcase
  end
  assign more = (scan_q < fill_q);
  assign full = (fill_q == itat_pkg::fill_t'(itat_pkg::TableEntries));

  assign byte_sum = {1'b0, rdata_q.bytes} + (itat_pkg::ByteW + 1)'(len_q);
  always_comb begin
    upd      = rdata_q;
    upd.pkts = (&rdata_q.pkts) ? rdata_q.pkts : rdata_q.pkts + 1'b1;
    upd.bytes = byte_sum[itat_pkg::ByteW] ? {itat_pkg::ByteW{1'b1}}
                                          : byte_sum[itat_pkg::ByteW-1:0];
  end

  always_comb begin
    ins.src   = src_q;
    ins.dst   = dst_q;
    ins.pkts  = itat_pkg::PktW'(1);
    ins.bytes = itat_pkg::bytes_t'(len_q);
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    scan_d   = scan_q;
    pend_d   = pend_q;
    pidx_d   = pidx_q;
    status_d = status_q;
    num_d    = num_q;
    res_d    = res_q;
    rd_en    = 1'b0;
    raddr    = scan_q[itat_pkg::IdxW-1:0];
    wr_en    = 1'b0;
    waddr    = pidx_q;
    wdata    = upd;
    ridx_ext = itat_pkg::fill_t'(ridx_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_d = '0;
          pend_d = 1'b0;
          res_d  = '0;
          num_d  = '0;
          if (operation_i == itat_pkg::OpRead) begin
            num_d = read_index_i;
            if (itat_pkg::fill_t'(read_index_i) < fill_q) begin
              state_d = S_READ;
            end else begin
              status_d = itat_pkg::StReadEmpty;
              state_d  = S_OUT;
            end
          end else if (mode_q == itat_pkg::KeyOff) begin
            status_d = itat_pkg::StIgnored;
            state_d  = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          pend_d  = 1'b0;
          state_d = S_UPD;
        end else if (more) begin
          rd_en  = 1'b1;
          scan_d = scan_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = scan_q[itat_pkg::IdxW-1:0];
        end else begin
          pend_d = 1'b0;
          if (full) begin
            status_d = itat_pkg::StFull;
          end else begin
            wr_en    = 1'b1;
            waddr    = fill_q[itat_pkg::IdxW-1:0];
            wdata    = ins;
            status_d = itat_pkg::StInserted;
            num_d    = itat_pkg::num_t'(fill_q);
            res_d    = ins;
            fill_d   = fill_q + 1'b1;
          end
          state_d = S_OUT;
        end
      end
      S_UPD: begin
        wr_en    = 1'b1;
        status_d = itat_pkg::StUpdated;
        num_d    = itat_pkg::num_t'(pidx_q);
        res_d    = upd;
        state_d  = S_OUT;
      end
      S_READ: begin
        rd_en   = 1'b1;
        raddr   = ridx_ext[itat_pkg::IdxW-1:0];
        state_d = S_RDATA;
      end
      S_RDATA: begin
        status_d = itat_pkg::StReadOk;
        res_d    = rdata_q;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= itat_pkg::KeySrc;
      fill_q  <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    status_q <= status_d;
    num_q    <= num_d;
    res_q    <= res_d;
    if (accept) begin
      src_q  <= source_address_i;
      dst_q  <= destination_address_i;
      len_q  <= ip_total_length_i;
      ridx_q <= read_index_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = (state_q == S_OUT);
  assign status_o            = status_q;
  assign entry_number_o      = num_q;
  assign entry_source_o      = res_q.src;
  assign entry_destination_o = res_q.dst;
  assign packet_total_o      = res_q.pkts;
  assign byte_total_o        = res_q.bytes;
  assign entries_used_o      = itat_pkg::used_t'(fill_q);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= itat_pkg::fill_t'(itat_pkg::TableEntries))
    else $error("fill level beyond table size");

  a_fill_only_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (out_valid_o && status_o == itat_pkg::StInserted))
    else $error("fill level moved without an insert");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= itat_pkg::StIgnored))
    else $error("result status out of range");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && (out_valid_o || pend_q)))
    else $error("input ready while a word is in work");

endmodule
